>>> sv/swmc_pkg.sv
// Shared constants, types and control bundles for the sliding window median cost block.
package swmc_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_W      = 7;
    localparam int COST_W     = 38;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W      = SAMPLE_W + CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } swmc_state_t;

    // Broadcast to every cell of the ordered chain.
    typedef struct packed {
        logic                       update;
        logic                       load;
        logic                       shift;
        logic                       full;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] old;
    } swmc_cell_ctrl_t;

    // Steers the accumulator and multiplier unit.
    typedef struct packed {
        logic clear;
        logic acc;
        logic is_lower;
        logic is_median;
        logic mul;
    } swmc_cost_ctrl_t;

endpackage

>>> sv/swmc_cell.sv
// One cell of the ordered chain: holds one sorted value and one read-out stage.
module swmc_cell
    import swmc_pkg::*;
(
    input  logic                       aclk,
    input  swmc_cell_ctrl_t            ctrl,
    input  logic                       w_valid,
    input  logic                       left_le,
    input  logic signed [SAMPLE_W-1:0] left_w,
    input  logic signed [SAMPLE_W-1:0] right_v,
    input  logic signed [SAMPLE_W-1:0] right_readout,
    output logic signed [SAMPLE_W-1:0] v_out,
    output logic signed [SAMPLE_W-1:0] w_out,
    output logic                       le_out,
    output logic signed [SAMPLE_W-1:0] readout_out
);

    logic signed [SAMPLE_W-1:0] v_reg;
    logic signed [SAMPLE_W-1:0] v_next;
    logic signed [SAMPLE_W-1:0] readout_reg;
    logic signed [SAMPLE_W-1:0] w;

    // Removing the departing value closes the gap from the right; inserting the
    // new sample opens a gap from the left.
    always_comb begin
        if (ctrl.full && !(v_reg < ctrl.old)) begin
            w = right_v;
        end else begin
            w = v_reg;
        end
        le_out = w_valid && (w <= ctrl.sample);
        if (le_out) begin
            v_next = w;
        end else if (left_le) begin
            v_next = ctrl.sample;
        end else begin
            v_next = left_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.update) begin
            v_reg <= v_next;
        end
        if (ctrl.load) begin
            readout_reg <= v_next;
        end else if (ctrl.shift) begin
            readout_reg <= right_readout;
        end
    end

    assign v_out       = v_reg;
    assign w_out       = w;
    assign readout_out = readout_reg;

endmodule

>>> sv/swmc_cost.sv
// Half sums, median capture and the final cost arithmetic.
module swmc_cost
    import swmc_pkg::*;
(
    input  logic                       aclk,
    input  swmc_cost_ctrl_t            ctrl,
    input  logic signed [SAMPLE_W-1:0] readout,
    input  logic [CNT_W-1:0]           lo_cnt,
    input  logic [CNT_W-1:0]           hi_cnt,
    output logic [COST_W-1:0]          cost
);

    logic signed [SUM_W-1:0]    lo_sum_reg;
    logic signed [SUM_W-1:0]    hi_sum_reg;
    logic signed [SAMPLE_W-1:0] med_reg;
    logic signed [SUM_W-1:0]    prod_lo_reg;
    logic signed [SUM_W-1:0]    prod_hi_reg;
    logic signed [SUM_W-1:0]    readout_ext;
    logic signed [SUM_W-1:0]    med_ext;
    logic signed [SUM_W-1:0]    cost_full;

    assign readout_ext = SUM_W'(readout);
    assign med_ext     = SUM_W'(med_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            lo_sum_reg <= '0;
            hi_sum_reg <= '0;
        end else if (ctrl.acc) begin
            if (ctrl.is_lower) begin
                lo_sum_reg <= lo_sum_reg + readout_ext;
            end else begin
                hi_sum_reg <= hi_sum_reg + readout_ext;
            end
        end
        if (ctrl.acc && ctrl.is_median) begin
            med_reg <= readout;
        end
        if (ctrl.mul) begin
            prod_lo_reg <= med_ext * $signed({1'b0, lo_cnt});
            prod_hi_reg <= med_ext * $signed({1'b0, hi_cnt});
        end
    end

    assign cost_full = (prod_lo_reg - lo_sum_reg) + (hi_sum_reg - prod_hi_reg);
    assign cost      = cost_full[COST_W-1:0];

endmodule

>>> sv/sliding_window_median_cost.sv
// Sliding window median cost: top level with control, history ring and ordered cell chain.
//
// Usage. Samples arrive on the s_ channel (s_valid, s_ready, s_sample) and
// costs leave on the m_ channel (m_valid, m_ready, m_window_cost). The window
// size is written on the cfg_ channel; a write clamps the value to the range
// one to the maximum window and empties the window. Write it only while the
// block is idle.
// While the window is still filling, an item only updates the ordered
// chain and no result is produced for it. Once the window holds K samples,
// every item passes from acceptance to the cost being offered on m_valid
// through these steps: the ordered chain is updated, the K ordered values
// are shifted out of the chain into the half-sum accumulators, the
// multiplier runs and the output register is loaded. The read-out shift
// over the chain is the longest step. A new item is accepted once the
// previous one has left the working states, even while the last cost
// still waits in the output register. If the receiver stalls, the block
// holds its next cost in the output stage and takes no further item until
// that register frees up.
// Reset sets the window size to one and empties the window; the history
// ring and the chain are not cleared, as only written entries are read.
module sliding_window_median_cost
    import swmc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_W-1:0]           cfg_window_size,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [COST_W-1:0]          m_window_cost
);

    swmc_state_t state_reg, state_next;

    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg;
    logic [COST_W-1:0] m_cost_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] old_reg;
    logic                       full_reg;

    // The history ring holds samples in arrival order.
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_WINDOW];
    logic [PTR_W-1:0]           hist_waddr;

    logic             in_accept;
    logic             cfg_accept;
    logic             out_load;
    logic [CNT_W-1:0] k_clamped;
    logic [CNT_W-1:0] wcnt;
    logic [CNT_W-1:0] lo_cnt;
    logic [CNT_W-1:0] hi_cnt;
    logic [CNT_W-1:0] ptr_plus;
    logic [CNT_W-1:0] cnt_ext;
    logic [COST_W-1:0] cost;

    swmc_cell_ctrl_t cell_ctrl;
    swmc_cost_ctrl_t cost_ctrl;

    logic signed [SAMPLE_W-1:0] cell_v       [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] cell_w       [MAX_WINDOW];
    logic                       cell_le      [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] cell_readout [MAX_WINDOW];
    logic                       cell_wvalid  [MAX_WINDOW];

    assign in_accept  = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);

    // A zero size is held as one, anything above the maximum as the maximum.
    always_comb begin
        if (cfg_window_size == '0) begin
            k_clamped = CNT_W'(1);
        end else if (32'(cfg_window_size) > MAX_WINDOW) begin
            k_clamped = CNT_W'(MAX_WINDOW);
        end else begin
            k_clamped = CNT_W'(cfg_window_size);
        end
    end

    assign lo_cnt   = k_reg >> 1;
    assign hi_cnt   = k_reg - lo_cnt;
    assign ptr_plus = CNT_W'(ptr_reg) + CNT_W'(1);
    assign cnt_ext  = CNT_W'(cnt_reg);

    // Once full, the entry to be overwritten is the oldest sample, and it is
    // read out in the same cycle as the new sample is written.
    assign hist_waddr = (fill_reg >= k_reg) ? ptr_reg : fill_reg[PTR_W-1:0];

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            hist_mem[hist_waddr] <= s_sample;
            old_reg              <= hist_mem[ptr_reg];
            sample_reg           <= s_sample;
            full_reg             <= (fill_reg >= k_reg);
        end
    end

    // Number of chain entries still valid after the departing value is removed.
    assign wcnt = full_reg ? (k_reg - CNT_W'(1)) : fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= CNT_W'(1);
            fill_reg  <= '0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_accept) begin
                k_reg    <= k_clamped;
                fill_reg <= '0;
                ptr_reg  <= '0;
            end else begin
                fill_reg <= fill_next;
                ptr_reg  <= ptr_next;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;

        cell_ctrl.update = 1'b0;
        cell_ctrl.load   = 1'b0;
        cell_ctrl.shift  = 1'b0;
        cell_ctrl.full   = full_reg;
        cell_ctrl.sample = sample_reg;
        cell_ctrl.old    = old_reg;

        cost_ctrl.clear     = 1'b0;
        cost_ctrl.acc       = 1'b0;
        cost_ctrl.is_lower  = (cnt_ext < lo_cnt);
        cost_ctrl.is_median = (cnt_ext == lo_cnt);
        cost_ctrl.mul       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cell_ctrl.update = 1'b1;
                cell_ctrl.load   = 1'b1;
                cost_ctrl.clear  = 1'b1;
                cnt_next         = '0;
                if (full_reg) begin
                    ptr_next   = (ptr_plus == k_reg) ? '0 : ptr_reg + PTR_W'(1);
                    state_next = ST_SUM;
                end else begin
                    fill_next = fill_reg + CNT_W'(1);
                    if ((fill_reg + CNT_W'(1)) == k_reg) begin
                        state_next = ST_SUM;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SUM: begin
                cell_ctrl.shift = 1'b1;
                cost_ctrl.acc   = 1'b1;
                cnt_next        = cnt_reg + PTR_W'(1);
                if (cnt_ext == (k_reg - CNT_W'(1))) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cost_ctrl.mul = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The ordered chain: each cell exchanges values with its two neighbours.
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic                       left_le;
        logic signed [SAMPLE_W-1:0] left_w;
        logic signed [SAMPLE_W-1:0] right_v;
        logic signed [SAMPLE_W-1:0] right_readout;

        assign cell_wvalid[i] = (CNT_W'(i) < wcnt);

        if (i == 0) begin : g_first
            assign left_le = 1'b1;
            assign left_w  = '0;
        end else begin : g_mid
            assign left_le = cell_le[i-1];
            assign left_w  = cell_w[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_last
            assign right_v       = '0;
            assign right_readout = '0;
        end else begin : g_inner
            assign right_v       = cell_v[i+1];
            assign right_readout = cell_readout[i+1];
        end

        swmc_cell u_cell (
            .aclk          (aclk),
            .ctrl          (cell_ctrl),
            .w_valid       (cell_wvalid[i]),
            .left_le       (left_le),
            .left_w        (left_w),
            .right_v       (right_v),
            .right_readout (right_readout),
            .v_out         (cell_v[i]),
            .w_out         (cell_w[i]),
            .le_out        (cell_le[i]),
            .readout_out   (cell_readout[i])
        );
    end

    swmc_cost u_cost (
        .aclk    (aclk),
        .ctrl    (cost_ctrl),
        .readout (cell_readout[0]),
        .lo_cnt  (lo_cnt),
        .hi_cnt  (hi_cnt),
        .cost    (cost)
    );

    // Output stage: holds a finished cost until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_cost_reg <= cost;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_window_cost = m_cost_reg;

endmodule

>>> sv/swmc_checker.sv
// Port-level checks for the sliding window median cost block, bound to the top level.
module swmc_checker
    import swmc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [COST_W-1:0] m_window_cost
);

    // A stalled cost stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_cost))
        else $error("stalled cost dropped or changed");

    // Reset leaves no cost on offer.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("cost offered after reset");

    // Each item passes through the chain update before the next item can be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted in back-to-back cycles");

    // A cost can never appear in the cycle straight after an item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("cost appeared too early");

endmodule

bind sliding_window_median_cost swmc_checker u_swmc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_window_cost (m_window_cost)
);
